// ===== hw/rtl/trrs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// trrs_pkg: shared types and constants of the timestamped ring record store
// Record layout, command and status codes, and sizes.
// ----------------------------------------------------------------------------
package trrs_pkg;

  localparam int Depth        = 16;
  localparam int PayloadBytes = 8;
  localparam int IdxW         = $clog2(Depth);
  localparam int CntW         = $clog2(Depth + 1);

  // valid payload bits of a record
  localparam logic [63:0] PayloadMask =
    (PayloadBytes >= 8) ? '1 : ((64'd1 << (8 * PayloadBytes)) - 64'd1);

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_READ   = 2'd1,
    CMD_PURGE  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_NO_START = 3'd2,
    ST_NO_END   = 3'd3,
    ST_TOO_MANY = 3'd4,
    ST_NO_PURGE = 3'd5
  } status_t;

  typedef struct packed {
    logic [31:0] rtime;
    logic [3:0]  len;
    logic [63:0] payload;
  } rec_t;

  // shift control shared by all cells
  typedef struct packed {
    logic shift;    // every cell takes its upstream neighbor
    logic clear;    // zero all cells
  } cell_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_EMIT, S_SHIFT, S_RESP
  } state_t;

endpackage : trrs_pkg
`default_nettype wire

// ===== hw/rtl/trrs_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// trrs_cell: one record slot of the rotating chain
// Holds one record, takes a written record or its neighbor's record on a shift.
// ----------------------------------------------------------------------------
module trrs_cell
  import trrs_pkg::*;
(
  input  wire logic      clk,
  input  wire cell_ctl_t ctl,
  input  wire logic      we,
  input  wire rec_t      din,
  input  wire rec_t      up,
  output rec_t           rec
);

  // clear, write, shift or hold
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      rec <= '0;
    end else if (we) begin
      rec <= din;
    end else if (ctl.shift) begin
      rec <= up;
    end
  end

endmodule : trrs_cell
`default_nettype wire

// ===== hw/rtl/timestamped_ring_record_store_top.sv =====
`default_nettype none
// Append and unknown commands answer from the response state; a range read or
// purge first rotates all Depth cells past cell 0 in a scan. An error answers
// after the scan, a read then emits its run records, and a purge shifts the
// purged records out before it answers. A new command is taken only in idle
// with the output register empty.
// Reset: store empty, capacity = 16, all cells zero.
// ----------------------------------------------------------------------------
// timestamped_ring_record_store_top: circular store of time-tagged records
// Records sit in a chain of cells; cell k holds the k-th oldest record.
// ----------------------------------------------------------------------------
module timestamped_ring_record_store_top
  import trrs_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [4:0]   cfg_wdata,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // tuser: cmd
  input  wire logic [1:0]   s_tuser,
  // tdata: key_time[31:0], upper_time[63:32], max_count[68:64],
  //        payload_len[72:69], payload[136:73], zero fill to 144
  input  wire logic [143:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic              m_tlast,
  // tuser: status
  output logic [2:0]        m_tuser,
  // tdata: out_time[31:0], out_len[35:32], out_payload[99:36],
  //        records_read[104:100], stored_count[109:105], min_time[141:110],
  //        latest_time[173:142], zero fill to 176
  output logic [175:0]      m_tdata
);

  // record chain
  rec_t             cells [Depth];
  rec_t             ups   [Depth];
  logic [Depth-1:0] cell_we;
  cell_ctl_t        ctl;
  logic             fill;
  rec_t             new_rec;

  // store state
  logic [CntW-1:0] cap, held;
  logic [31:0]     sum_min, sum_lt;

  // registered item
  logic [1:0]      cmd;
  logic [31:0]     key, upper;
  logic [4:0]      maxc;
  logic [3:0]      plen;
  logic [63:0]     pl;

  // sequencing
  state_t          state, state_next;
  logic [CntW-1:0] step;      // cells shifted so far
  logic [CntW-1:0] sidx, nrun, npurge;
  logic            found_s, run_open, purge_open;
  logic [31:0]     rem_min;
  status_t         st;

  // output register
  logic            ov;
  status_t         o_st;
  logic            o_last;
  rec_t            o_rec;
  logic [CntW-1:0] o_rr, o_held;
  logic [31:0]     o_min, o_lt;

  logic            out_free, in_go;
  logic            scan_adv, scan_done, emit_adv, emit_win, emit_last, shift_adv;
  logic            rd_ok, app_full, app_we, resp_go;
  logic [CntW-1:0] remain, run_end;
  logic [31:0]     t0, app_min;

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    trrs_cell u_cell (
      .clk(clk), .ctl(ctl), .we(cell_we[g]), .din(new_rec), .up(ups[g]),
      .rec(cells[g])
    );
  end

  assign out_free  = !ov || m_tready;
  assign s_tready  = (state == S_IDLE) && !ov;
  assign in_go     = s_tvalid && s_tready;
  assign resp_go   = (state == S_RESP) && out_free;

  // cell 0 shows the record whose index equals step
  assign t0        = cells[0].rtime;
  assign run_end   = sidx + nrun;
  assign remain    = held - npurge;
  assign scan_adv  = (state == S_SCAN) && (step != CntW'(Depth));
  assign scan_done = (state == S_SCAN) && (step == CntW'(Depth));
  assign emit_win  = (step >= sidx) && (step < run_end);
  assign emit_last = (step == run_end - CntW'(1));
  assign emit_adv  = (state == S_EMIT) && (step != CntW'(Depth)) && (!emit_win || out_free);
  assign shift_adv = (state == S_SHIFT) && (step != npurge);
  assign rd_ok     = found_s && (nrun != '0) && (nrun <= maxc);
  assign app_full  = (held >= cap);
  assign app_we    = resp_go && (cmd == CMD_APPEND) && !app_full;
  assign app_min   = (held == '0 || key < sum_min) ? key : sum_min;
  assign new_rec   = '{rtime: key, len: plen, payload: pl};

  // chain wiring: cell k takes cell k+1, the top cell wraps or takes zero
  always_comb begin
    for (int k = 0; k < Depth - 1; k++) begin
      ups[k] = cells[k+1];
    end
    ups[Depth-1] = fill ? rec_t'('0) : cells[0];
  end

  // append writes the cell just past the newest record
  always_comb begin
    for (int k = 0; k < Depth; k++) begin
      cell_we[k] = app_we && (held == CntW'(k));
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_go) begin
          if (s_tuser inside {CMD_READ, CMD_PURGE}) state_next = S_SCAN;
          else state_next = S_RESP;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          if (cmd == CMD_READ && rd_ok) state_next = S_EMIT;
          else if (cmd == CMD_PURGE && npurge != '0) state_next = S_SHIFT;
          else state_next = S_RESP;
        end
      end
      S_EMIT:  if (step == CntW'(Depth)) state_next = S_IDLE;
      S_SHIFT: if (step == npurge) state_next = S_RESP;
      S_RESP:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // cell control
  always_comb begin
    ctl.clear = rst || cfg_we;
    ctl.shift = scan_adv || emit_adv || shift_adv;
  end
  assign fill = (state == S_SHIFT);

  // sequencing and store state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cap     <= CntW'(Depth < 16 ? Depth : 16);
      held    <= '0;
      sum_min <= '0;
      sum_lt  <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_wdata == '0) cap <= CntW'(1);
        else if (cfg_wdata > 5'(Depth)) cap <= CntW'(Depth);
        else cap <= CntW'(cfg_wdata);
        held    <= '0;
        sum_min <= '0;
        sum_lt  <= '0;
      end else begin
        case (state)
          S_IDLE: begin
            if (in_go) begin
              cmd        <= s_tuser;
              key        <= s_tdata[31:0];
              upper      <= s_tdata[63:32];
              maxc       <= s_tdata[68:64];
              plen       <= (s_tdata[72:69] > 4'(PayloadBytes)) ? 4'(PayloadBytes)
                                                                : s_tdata[72:69];
              pl         <= s_tdata[136:73] & PayloadMask;
              step       <= '0;
              sidx       <= '0;
              nrun       <= '0;
              npurge     <= '0;
              found_s    <= 1'b0;
              run_open   <= 1'b0;
              purge_open <= 1'b1;
              rem_min    <= '1;
              st         <= ST_OK;
            end
          end
          S_SCAN: begin
            if (scan_adv) begin
              step <= step + CntW'(1);
              if (step < held) begin
                // count the purgeable prefix, track the minimum of what stays
                if (purge_open && t0 <= key) begin
                  npurge <= npurge + CntW'(1);
                end else begin
                  purge_open <= 1'b0;
                  if (t0 < rem_min) rem_min <= t0;
                end
                // find the run start, then extend it while in bound
                if (!found_s) begin
                  if (t0 >= key) begin
                    found_s  <= 1'b1;
                    sidx     <= step;
                    run_open <= (t0 <= upper);
                    nrun     <= (t0 <= upper) ? CntW'(1) : '0;
                  end
                end else if (run_open) begin
                  if (t0 <= upper) nrun <= nrun + CntW'(1);
                  else run_open <= 1'b0;
                end
              end
            end else begin
              step <= '0;
              if (cmd == CMD_READ) begin
                if (!found_s) st <= ST_NO_START;
                else if (nrun == '0) st <= ST_NO_END;
                else if (nrun > maxc) st <= ST_TOO_MANY;
              end else if (npurge == '0) begin
                st <= ST_NO_PURGE;
              end else begin
                held <= remain;
                if (remain == '0) begin
                  sum_min <= '0;
                  sum_lt  <= '0;
                end else begin
                  sum_min <= rem_min;
                end
              end
            end
          end
          S_EMIT: begin
            if (emit_adv) step <= step + CntW'(1);
          end
          S_SHIFT: begin
            if (shift_adv) step <= step + CntW'(1);
          end
          S_RESP: begin
            if (app_we) begin
              held    <= held + CntW'(1);
              sum_min <= app_min;
              sum_lt  <= key;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // output valid: load on a result, drop after the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (resp_go || (emit_adv && emit_win)) begin
      ov <= 1'b1;
    end else if (m_tready) begin
      ov <= 1'b0;
    end
  end

  // output data
  always_ff @(posedge clk) begin
    if (emit_adv && emit_win) begin
      o_st   <= ST_OK;
      o_last <= emit_last;
      o_rec  <= cells[0];
      o_rr   <= nrun;
      o_held <= held;
      o_min  <= sum_min;
      o_lt   <= sum_lt;
    end else if (resp_go) begin
      o_last <= 1'b1;
      o_rec  <= '0;
      if (cmd == CMD_APPEND) begin
        o_rr <= '0;
        if (app_full) begin
          o_st   <= ST_FULL;
          o_held <= held;
          o_min  <= sum_min;
          o_lt   <= sum_lt;
        end else begin
          o_st   <= ST_OK;
          o_held <= held + CntW'(1);
          o_min  <= app_min;
          o_lt   <= key;
        end
      end else begin
        o_st   <= st;
        o_rr   <= (st == ST_TOO_MANY) ? nrun : '0;
        o_held <= held;
        o_min  <= sum_min;
        o_lt   <= sum_lt;
      end
    end
  end

  assign m_tvalid = ov;
  assign m_tlast  = o_last;
  assign m_tuser  = o_st;
  assign m_tdata  = {2'b00, o_lt, o_min, o_held, o_rr, o_rec.payload, o_rec.len,
                     o_rec.rtime};

endmodule : timestamped_ring_record_store_top
`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the timestamped ring record store
// Drives commands over the input stream and predicts every result with a
// behavioral copy of the store. Each output transfer is checked field by field
// against the oldest pending prediction. Covers capacity settings, full and
// empty stores, wrap-around, range errors, purges and output back-pressure.
// ----------------------------------------------------------------------------
module testbench;
  import trrs_pkg::*;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam int         MaxShown    = 10;

  typedef struct packed {
    status_t     status;
    logic [31:0] rtime;
    logic [3:0]  len;
    logic [63:0] payload;
    logic        last;
    logic [4:0]  run_len;
    logic [4:0]  held;
    logic [31:0] min_time;
    logic [31:0] latest_time;
  } rec_result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [4:0]   cfg_wdata = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [1:0]   s_tuser = '0;
  logic [143:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic         m_tlast;
  logic [2:0]   m_tuser;
  logic [175:0] m_tdata;

  // behavioral copy of the store
  logic [31:0]  ring_time [Depth];
  logic [3:0]   ring_len [Depth];
  logic [63:0]  ring_payload [Depth];
  int           ring_wr;
  int           ring_held;
  int           ring_cap;
  rec_result_t  pending_results[$];

  int           mismatches = 0;
  int           hold_cycles = 0;
  int           rx_gap = 0;
  bit           steady = 1'b0;
  logic [31:0]  time_base;

  timestamped_ring_record_store_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser),
    .s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tlast(m_tlast), .m_tuser(m_tuser), .m_tdata(m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  function automatic int ring_slot(int i);
    int oldest;
    oldest = (ring_wr + ring_cap - ring_held) % ring_cap;
    return (oldest + i) % ring_cap;
  endfunction

  task automatic clear_ring();
    for (int i = 0; i < Depth; i++) begin
      ring_time[i] = '0;
      ring_len[i] = '0;
      ring_payload[i] = '0;
    end
    ring_wr = 0;
    ring_held = 0;
  endtask

  // queue one result, with the summary taken from the current store
  task automatic push_result(status_t st, logic [31:0] t, logic [3:0] len,
                             logic [63:0] pl, logic last, int run_len);
    rec_result_t r;
    logic [31:0] mn, lt;
    mn = '0;
    lt = '0;
    if (ring_held > 0) begin
      mn = ring_time[ring_slot(0)];
      for (int i = 1; i < ring_held; i++)
        if (ring_time[ring_slot(i)] < mn) mn = ring_time[ring_slot(i)];
      lt = ring_time[(ring_wr + ring_cap - 1) % ring_cap];
    end
    r.status = st;
    r.rtime = t;
    r.len = len;
    r.payload = pl;
    r.last = last;
    r.run_len = run_len[4:0];
    r.held = ring_held[4:0];
    r.min_time = mn;
    r.latest_time = lt;
    pending_results.push_back(r);
  endtask

  task automatic predict_item(logic [1:0] cmd, logic [31:0] key, logic [31:0] upper,
                              logic [4:0] maxc, logic [3:0] plen, logic [63:0] pl);
    int s, e, n, p;
    case (cmd)
      CMD_APPEND: begin
        if (ring_held >= ring_cap) begin
          push_result(ST_FULL, '0, '0, '0, 1'b1, 0);
        end else begin
          ring_time[ring_wr] = key;
          ring_len[ring_wr] = (plen > PayloadBytes) ? 4'(PayloadBytes) : plen;
          ring_payload[ring_wr] = pl;
          ring_wr = (ring_wr + 1) % ring_cap;
          ring_held++;
          push_result(ST_OK, '0, '0, '0, 1'b1, 0);
        end
      end
      CMD_READ: begin
        for (s = 0; s < ring_held; s++)
          if (ring_time[ring_slot(s)] >= key) break;
        if (s >= ring_held) begin
          push_result(ST_NO_START, '0, '0, '0, 1'b1, 0);
        end else if (ring_time[ring_slot(s)] > upper) begin
          push_result(ST_NO_END, '0, '0, '0, 1'b1, 0);
        end else begin
          e = s;
          while (e + 1 < ring_held && ring_time[ring_slot(e + 1)] <= upper) e++;
          n = e - s + 1;
          if (n > maxc) begin
            push_result(ST_TOO_MANY, '0, '0, '0, 1'b1, n);
          end else begin
            for (int i = 0; i < n; i++) begin
              p = ring_slot(s + i);
              push_result(ST_OK, ring_time[p], ring_len[p], ring_payload[p],
                          i + 1 == n, n);
            end
          end
        end
      end
      CMD_PURGE: begin
        n = 0;
        while (n < ring_held && ring_time[ring_slot(n)] <= key) n++;
        if (n == 0) begin
          push_result(ST_NO_PURGE, '0, '0, '0, 1'b1, 0);
        end else begin
          for (int i = 0; i < n; i++) begin
            p = ring_slot(0);
            ring_time[p] = '0;
            ring_len[p] = '0;
            ring_payload[p] = '0;
            ring_held--;
          end
          push_result(ST_OK, '0, '0, '0, 1'b1, 0);
        end
      end
      default: push_result(ST_OK, '0, '0, '0, 1'b1, 0);
    endcase
  endtask

  // ------------------------------------------------------------------ stimulus
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // offer one item, wait for its transfer and predict its results
  task automatic send_item(logic [1:0] cmd, logic [31:0] key, logic [31:0] upper,
                           logic [4:0] maxc, logic [3:0] plen, logic [63:0] pl);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {7'd0, pl, plen, maxc, upper, key};
    do @(posedge clk); while (!s_tready);
    predict_item(cmd, key, upper, maxc, plen, pl);
  endtask

  // drain all results, then write the capacity register
  task automatic write_capacity(logic [4:0] v);
    int c;
    s_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (2 * Depth + 8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    c = v;
    if (c < 1) c = 1;
    if (c > Depth) c = Depth;
    ring_cap = c;
    clear_ring();
  endtask

  task automatic append_next();
    time_base = time_base + $urandom_range(0, 20);
    send_item(CMD_APPEND, time_base, $urandom, 5'($urandom), 4'($urandom_range(0, 15)),
              {$urandom, $urandom});
  endtask

  // -------------------------------------------------------------------- tests
  task automatic test_directed();
    send_item(CMD_READ, 32'd0, 32'hFFFF_FFFF, 5'd16, 4'd0, '0);
    send_item(CMD_PURGE, 32'hFFFF_FFFF, '0, '0, '0, '0);
    send_item(CMD_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31, 4'd15, '1);
    send_item(CMD_APPEND, 32'd0, '0, '0, 4'd0, 64'd0);
    send_item(CMD_APPEND, 32'd5, '0, '0, 4'd8, 64'h0123_4567_89AB_CDEF);
    send_item(CMD_APPEND, 32'd3, '0, '0, 4'd3, 64'hA5A5);
    send_item(CMD_APPEND, 32'hFFFF_FFFF, '1, 5'd31, 4'd15, '1);
    send_item(CMD_READ, 32'd0, 32'hFFFF_FFFF, 5'd31, '0, '0);
    send_item(CMD_READ, 32'd0, 32'hFFFF_FFFF, 5'd0, '0, '0);
    send_item(CMD_READ, 32'd0, 32'hFFFF_FFFF, 5'd3, '0, '0);
    send_item(CMD_READ, 32'd4, 32'd4, 5'd16, '0, '0);
    send_item(CMD_READ, 32'd1, 32'd4, 5'd16, '0, '0);
    send_item(CMD_READ, 32'd6, 32'hFFFF_FFFE, 5'd16, '0, '0);
    send_item(CMD_PURGE, 32'd0, '0, '0, '0, '0);
    send_item(CMD_PURGE, 32'd4, '0, '0, '0, '0);
    send_item(CMD_PURGE, 32'd5, '0, '0, '0, '0);
    send_item(CMD_UNKNOWN, '0, '0, '0, '0, '0);
    send_item(CMD_PURGE, 32'hFFFF_FFFF, '0, '0, '0, '0);
  endtask

  task automatic test_capacity_edges();
    // zero acts as one slot
    write_capacity(5'd0);
    send_item(CMD_APPEND, 32'd7, '0, '0, 4'd1, 64'h11);
    send_item(CMD_APPEND, 32'd8, '0, '0, 4'd1, 64'h22);
    send_item(CMD_READ, 32'd0, 32'd100, 5'd1, '0, '0);
    // above the depth saturates
    write_capacity(5'd31);
    for (int i = 0; i < Depth + 1; i++) send_item(CMD_APPEND, 32'(i), '0, '0,
      4'(i), {2{$urandom}});
    send_item(CMD_READ, 32'd0, 32'hFFFF_FFFF, 5'd16, '0, '0);
    // wrap a small ring
    write_capacity(5'd3);
    for (int i = 0; i < 8; i++) begin
      send_item(CMD_APPEND, 32'(10 * i), '0, '0, 4'd2, 64'(i));
      if (i % 2 == 1) send_item(CMD_PURGE, 32'(10 * i - 10), '0, '0, '0, '0);
      send_item(CMD_READ, 32'd0, 32'hFFFF_FFFF, 5'd3, '0, '0);
    end
  endtask

  task automatic test_random_traffic(int count);
    int r;
    logic [31:0] lo;
    time_base = $urandom_range(0, 32'hF000_0000);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        append_next();
      end else if (r < 75) begin
        lo = time_base - $urandom_range(0, 120);
        send_item(CMD_READ, lo, lo + $urandom_range(0, 120),
                  ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, 16)),
                  4'($urandom), {$urandom, $urandom});
      end else if (r < 88) begin
        send_item(CMD_PURGE, time_base - $urandom_range(0, 150), $urandom, 5'($urandom),
                  4'($urandom), {$urandom, $urandom});
      end else if (r < 93) begin
        // out-of-order record time
        send_item(CMD_APPEND, time_base - $urandom_range(0, 60), $urandom, 5'($urandom),
                  4'($urandom), {$urandom, $urandom});
      end else if (r < 96) begin
        send_item(CMD_UNKNOWN, $urandom, $urandom, 5'($urandom), 4'($urandom),
                  {$urandom, $urandom});
      end else begin
        send_item(2'($urandom_range(1, 2)), $urandom, $urandom, 5'($urandom),
                  4'($urandom), {$urandom, $urandom});
      end
    end
  endtask

  // stall the output while reads keep coming, so the input backs up
  task automatic test_output_stall();
    write_capacity(5'd16);
    steady = 1'b1;
    time_base = 32'd1000;
    for (int i = 0; i < Depth; i++) append_next();
    hold_cycles = 400;
    for (int i = 0; i < 4; i++)
      send_item(CMD_READ, 32'd0, 32'hFFFF_FFFF, 5'd16, '0, '0);
    steady = 1'b0;
    // sender pauses until everything is out
    s_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    send_item(CMD_PURGE, time_base, '0, '0, '0, '0);
  endtask

  initial begin
    ring_cap = Depth;
    clear_ring();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_capacity_edges();
    write_capacity(5'd4);
    test_random_traffic(10);
    write_capacity(5'd1);
    test_random_traffic(6);
    write_capacity(5'd16);
    steady = 1'b1;
    test_random_traffic(15);
    steady = 1'b0;
    write_capacity(5'd9);
    test_random_traffic(15);
    test_output_stall();
    write_capacity(5'd16);
    test_random_traffic(10);
    s_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (2 * Depth + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // --------------------------------------------------------------- receiver
  // hold off on request, otherwise insert random stalls
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (!steady && $urandom_range(0, 3) == 0)
          rx_gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                : $urandom_range(1, 3);
      end
    end
  end

  // check each output transfer against the oldest prediction
  always @(posedge clk) begin
    rec_result_t want, got;
    if (!rst && m_tvalid && m_tready) begin
      got.status = status_t'(m_tuser);
      got.rtime = m_tdata[31:0];
      got.len = m_tdata[35:32];
      got.payload = m_tdata[99:36];
      got.last = m_tlast;
      got.run_len = m_tdata[104:100];
      got.held = m_tdata[109:105];
      got.min_time = m_tdata[141:110];
      got.latest_time = m_tdata[173:142];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxShown) $display("unexpected result: %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MaxShown)
            $display("mismatch:\n  expected %p\n  actual   %p", want, got);
        end
      end
    end
  end

endmodule

// ===== timestamped_ring_record_store_top.f =====
hw/rtl/trrs_pkg.sv
hw/rtl/trrs_cell.sv
hw/rtl/timestamped_ring_record_store_top.sv
tb/testbench.sv
